### sv/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants for the strongly connected component search block.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned DefMaxVertices = 64;
  localparam int unsigned DefMaxEdges    = 1024;

  localparam int unsigned ActionW    = 2;
  localparam int unsigned VertexW    = 6;
  localparam int unsigned VertCountW = 7;

  // request action codes
  localparam logic [ActionW-1:0] ActAddEdge = 2'd0;
  localparam logic [ActionW-1:0] ActClear   = 2'd1;
  localparam logic [ActionW-1:0] ActRun     = 2'd2;
  localparam logic [ActionW-1:0] ActNop     = 2'd3;

endpackage

### sv/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/strongly_connected_components.sv
// ----------------------------------------------------------------------------
// strongly_connected_components
// Edge store and Tarjan component search over on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_valid_i/in_ready_o channel. An add-edge request
//   does a list lookup, then the writes; clear and a no-op are handled as
//   they are taken. Dropped edges (vertex at or above vertex_count, or a full
//   store) set the edges_dropped flag until the next clear.
//   A run request walks the graph with an explicit call stack kept in RAM.
//   Each vertex costs a root scan, a visit, a frame pop and the reload of
//   its parent frame; each edge and each reported vertex cost further
//   steps. The run time is set by the single read port of each memory in
//   the read-modify-write sequencer.
//   Results leave on out_valid_o/out_ready_i, one per vertex, in stack-pop
//   order per component. The last result of a component carries
//   last_of_component_o, the last of the run carries last_of_run_o. One
//   result is held back internally so the final one can be marked.
//   A stalled receiver holds the output register; the sequencer then waits
//   on its next emission. No new request is taken until the run is done.
//   Reset empties all edge lists and zeroes vertex_count and the flags; no
//   clearing pass is needed since lists and visits are tracked by flops.
//   Write vertex_count via cfg_we_i/cfg_wdata_i while idle (not enforced).
// ----------------------------------------------------------------------------
module strongly_connected_components #(
  parameter int unsigned MAX_VERTICES = scc_pkg::DefMaxVertices,
  parameter int unsigned MAX_EDGES    = scc_pkg::DefMaxEdges
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scc_pkg::VertCountW-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [scc_pkg::ActionW-1:0]     action_i,
  input  logic [scc_pkg::VertexW-1:0]     src_vertex_i,
  input  logic [scc_pkg::VertexW-1:0]     dst_vertex_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [scc_pkg::VertexW-1:0]     vertex_o,
  output logic [scc_pkg::VertexW-1:0]     component_root_o,
  output logic                            last_of_component_o,
  output logic                            last_of_run_o,
  output logic                            edges_dropped_o
);

  localparam int unsigned VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EC   = $clog2(MAX_EDGES + 1);
  localparam int unsigned CALW = VW + 1 + EW;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_ADD_WR  = 14'b00000000000010,
    ST_ROOT    = 14'b00000000000100,
    ST_VISIT   = 14'b00000000001000,
    ST_LOOP    = 14'b00000000010000,
    ST_EDGE    = 14'b00000000100000,
    ST_LOW     = 14'b00000001000000,
    ST_COMP_RD = 14'b00000010000000,
    ST_COMP_WR = 14'b00000100000000,
    ST_PAR_RD  = 14'b00001000000000,
    ST_PAR_V   = 14'b00010000000000,
    ST_PAR_L   = 14'b00100000000000,
    ST_FLUSH   = 14'b01000000000000,
    ST_SPARE   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [scc_pkg::VertCountW-1:0] vcount_q, vcount_d;
  logic [CW-1:0]                  n;

  logic [EC-1:0]           stored_q, stored_d;
  logic                    dropped_q, dropped_d;
  logic [MAX_VERTICES-1:0] list_valid_q, list_valid_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [MAX_VERTICES-1:0] on_stack_q, on_stack_d;
  logic [VW-1:0]           src_q, src_d;
  logic [VW-1:0]           dst_q, dst_d;

  logic [CW-1:0] root_q, root_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ctop_q, ctop_d;
  logic [CW-1:0] call_top_q, call_top_d;
  logic [VW-1:0] vw_q, vw_d;

  // cached top call frame
  logic [VW-1:0] cur_v_q, cur_v_d;
  logic          cur_null_q, cur_null_d;
  logic [EW-1:0] cur_c_q, cur_c_d;
  logic [EW-1:0] cur_last_q, cur_last_d;
  logic [VW-1:0] cur_idx_q, cur_idx_d;
  logic [VW-1:0] cur_low_q, cur_low_d;

  // held-back result
  logic          pend_valid_q, pend_valid_d;
  logic [VW-1:0] pend_v_q, pend_v_d;
  logic [VW-1:0] pend_root_q, pend_root_d;
  logic          pend_loc_q, pend_loc_d;
  logic          pend_drop_q, pend_drop_d;

  logic          out_valid_q, out_valid_d;
  logic [VW-1:0] out_v_q, out_v_d;
  logic [VW-1:0] out_root_q, out_root_d;
  logic          out_loc_q, out_loc_d;
  logic          out_lor_q, out_lor_d;
  logic          out_drop_q, out_drop_d;

  // memory ports
  logic              tgt_we, tgt_re;
  logic [EW-1:0]     tgt_waddr, tgt_raddr;
  logic [VW-1:0]     tgt_wdata, tgt_rdata;
  logic              lnk_we, lnk_re;
  logic [EW-1:0]     lnk_waddr, lnk_raddr, lnk_wdata, lnk_rdata;
  logic              lst_we, lst_re;
  logic [VW-1:0]     lst_waddr, lst_raddr;
  logic [2*EW-1:0]   lst_wdata, lst_rdata;
  logic              vin_we, vin_re;
  logic [VW-1:0]     vin_waddr, vin_raddr;
  logic [2*VW-1:0]   vin_wdata, vin_rdata;
  logic              cst_we, cst_re;
  logic [VW-1:0]     cst_waddr, cst_raddr, cst_wdata, cst_rdata;
  logic              cal_we, cal_re;
  logic [VW-1:0]     cal_waddr, cal_raddr;
  logic [CALW-1:0]   cal_wdata, cal_rdata;

  logic          in_accept;
  logic          slot_free;
  logic          add_drop;
  logic [VW-1:0] w_edge;
  logic [VW-1:0] w_comp;
  logic [CW-1:0] ctop_m1;
  logic [CW-1:0] call_m1;

  assign n = (vcount_q > scc_pkg::VertCountW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                             : CW'(vcount_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign add_drop   = (scc_pkg::VertCountW'(src_vertex_i) >= scc_pkg::VertCountW'(n)) ||
                      (scc_pkg::VertCountW'(dst_vertex_i) >= scc_pkg::VertCountW'(n)) ||
                      (stored_q >= EC'(MAX_EDGES));
  assign w_edge   = tgt_rdata;
  assign w_comp   = cst_rdata;
  assign ctop_m1  = ctop_q - CW'(1);
  assign call_m1  = call_top_q - CW'(1);

  always_comb begin
    state_d       = state_q;
    vcount_d      = cfg_we_i ? cfg_wdata_i : vcount_q;
    stored_d      = stored_q;
    dropped_d     = dropped_q;
    list_valid_d  = list_valid_q;
    visited_d     = visited_q;
    on_stack_d    = on_stack_q;
    src_d         = src_q;
    dst_d         = dst_q;
    root_d        = root_q;
    cnt_d         = cnt_q;
    ctop_d        = ctop_q;
    call_top_d    = call_top_q;
    vw_d          = vw_q;
    cur_v_d       = cur_v_q;
    cur_null_d    = cur_null_q;
    cur_c_d       = cur_c_q;
    cur_last_d    = cur_last_q;
    cur_idx_d     = cur_idx_q;
    cur_low_d     = cur_low_q;
    pend_valid_d  = pend_valid_q;
    pend_v_d      = pend_v_q;
    pend_root_d   = pend_root_q;
    pend_loc_d    = pend_loc_q;
    pend_drop_d   = pend_drop_q;
    out_valid_d   = out_valid_q & !out_ready_i;
    out_v_d       = out_v_q;
    out_root_d    = out_root_q;
    out_loc_d     = out_loc_q;
    out_lor_d     = out_lor_q;
    out_drop_d    = out_drop_q;

    tgt_we = 1'b0; tgt_waddr = stored_q[EW-1:0]; tgt_wdata = dst_q;
    tgt_re = 1'b0; tgt_raddr = cur_c_q;
    lnk_we = 1'b0; lnk_waddr = lst_rdata[EW-1:0]; lnk_wdata = stored_q[EW-1:0];
    lnk_re = 1'b0; lnk_raddr = cur_c_q;
    lst_we = 1'b0; lst_waddr = src_q; lst_wdata = '0;
    lst_re = 1'b0; lst_raddr = src_vertex_i[VW-1:0];
    vin_we = 1'b0; vin_waddr = vw_q; vin_wdata = '0;
    vin_re = 1'b0; vin_raddr = w_edge;
    cst_we = 1'b0; cst_waddr = ctop_q[VW-1:0]; cst_wdata = vw_q;
    cst_re = 1'b0; cst_raddr = ctop_m1[VW-1:0];
    cal_we = 1'b0; cal_waddr = call_top_q[VW-1:0]; cal_wdata = '0;
    cal_re = 1'b0; cal_raddr = call_m1[VW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (action_i)
            scc_pkg::ActAddEdge: begin
              if (add_drop) begin
                dropped_d = 1'b1;
              end else begin
                // look up the source list while the request is latched
                lst_re  = 1'b1;
                src_d   = src_vertex_i[VW-1:0];
                dst_d   = dst_vertex_i[VW-1:0];
                state_d = ST_ADD_WR;
              end
            end
            scc_pkg::ActClear: begin
              list_valid_d = '0;
              stored_d     = '0;
              dropped_d    = 1'b0;
            end
            scc_pkg::ActRun: begin
              visited_d  = '0;
              on_stack_d = '0;
              ctop_d     = '0;
              call_top_d = '0;
              cnt_d      = '0;
              root_d     = '0;
              state_d    = ST_ROOT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_WR: begin
        tgt_we    = 1'b1;
        lnk_we    = list_valid_q[src_q];
        lst_we    = 1'b1;
        lst_wdata = {(list_valid_q[src_q] ? lst_rdata[2*EW-1:EW] : stored_q[EW-1:0]),
                     stored_q[EW-1:0]};
        list_valid_d[src_q] = 1'b1;
        stored_d  = stored_q + EC'(1);
        state_d   = ST_IDLE;
      end
      ST_ROOT: begin
        if (root_q == n) begin
          state_d = ST_FLUSH;
        end else if (visited_q[root_q[VW-1:0]]) begin
          root_d = root_q + CW'(1);
        end else begin
          lst_re    = 1'b1;
          lst_raddr = root_q[VW-1:0];
          vw_d      = root_q[VW-1:0];
          state_d   = ST_VISIT;
        end
      end
      ST_VISIT: begin
        vin_we    = 1'b1;
        vin_wdata = {cnt_q[VW-1:0], cnt_q[VW-1:0]};
        cst_we    = 1'b1;
        cal_we    = 1'b1;
        cal_wdata = {vw_q, !list_valid_q[vw_q], lst_rdata[2*EW-1:EW]};
        cur_v_d    = vw_q;
        cur_null_d = !list_valid_q[vw_q];
        cur_c_d    = lst_rdata[2*EW-1:EW];
        cur_last_d = lst_rdata[EW-1:0];
        cur_idx_d  = cnt_q[VW-1:0];
        cur_low_d  = cnt_q[VW-1:0];
        cnt_d      = cnt_q + CW'(1);
        ctop_d     = ctop_q + CW'(1);
        call_top_d = call_top_q + CW'(1);
        visited_d[vw_q]  = 1'b1;
        on_stack_d[vw_q] = 1'b1;
        state_d    = ST_LOOP;
      end
      ST_LOOP: begin
        if (cur_null_q) begin
          call_top_d = call_m1;
          state_d    = (cur_low_q == cur_idx_q) ? ST_COMP_RD : ST_PAR_RD;
        end else begin
          tgt_re  = 1'b1;
          lnk_re  = 1'b1;
          state_d = ST_EDGE;
        end
      end
      ST_EDGE: begin
        // advance the cursor of the top frame and write it back
        if (cur_c_q == cur_last_q) begin
          cur_null_d = 1'b1;
        end else begin
          cur_c_d = lnk_rdata;
        end
        cal_we    = 1'b1;
        cal_waddr = call_m1[VW-1:0];
        cal_wdata = {cur_v_q, (cur_c_q == cur_last_q),
                     ((cur_c_q == cur_last_q) ? cur_c_q : lnk_rdata)};
        if (CW'(w_edge) >= n) begin
          state_d = ST_LOOP;
        end else if (!visited_q[w_edge]) begin
          lst_re    = 1'b1;
          lst_raddr = w_edge;
          vw_d      = w_edge;
          state_d   = ST_VISIT;
        end else if (on_stack_q[w_edge]) begin
          vin_re  = 1'b1;
          state_d = ST_LOW;
        end else begin
          state_d = ST_LOOP;
        end
      end
      ST_LOW: begin
        if (vin_rdata[2*VW-1:VW] < cur_low_q) begin
          cur_low_d = vin_rdata[2*VW-1:VW];
          vin_we    = 1'b1;
          vin_waddr = cur_v_q;
          vin_wdata = {cur_idx_q, vin_rdata[2*VW-1:VW]};
        end
        state_d = ST_LOOP;
      end
      ST_COMP_RD: begin
        cst_re  = 1'b1;
        state_d = ST_COMP_WR;
      end
      ST_COMP_WR: begin
        if (!pend_valid_q || slot_free) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_v_d     = pend_v_q;
            out_root_d  = pend_root_q;
            out_loc_d   = pend_loc_q;
            out_lor_d   = 1'b0;
            out_drop_d  = pend_drop_q;
          end
          pend_valid_d = 1'b1;
          pend_v_d     = w_comp;
          pend_root_d  = cur_v_q;
          pend_loc_d   = (w_comp == cur_v_q);
          pend_drop_d  = dropped_q;
          ctop_d       = ctop_m1;
          on_stack_d[w_comp] = 1'b0;
          state_d = (w_comp == cur_v_q) ? ST_PAR_RD : ST_COMP_RD;
        end
      end
      ST_PAR_RD: begin
        if (call_top_q == '0) begin
          state_d = ST_ROOT;
        end else begin
          cal_re  = 1'b1;
          state_d = ST_PAR_V;
        end
      end
      ST_PAR_V: begin
        cur_v_d    = cal_rdata[CALW-1:EW+1];
        cur_null_d = cal_rdata[EW];
        cur_c_d    = cal_rdata[EW-1:0];
        vin_re     = 1'b1;
        vin_raddr  = cal_rdata[CALW-1:EW+1];
        lst_re     = 1'b1;
        lst_raddr  = cal_rdata[CALW-1:EW+1];
        state_d    = ST_PAR_L;
      end
      ST_PAR_L: begin
        // fold the returning child's low link into the parent
        cur_idx_d  = vin_rdata[2*VW-1:VW];
        cur_last_d = lst_rdata[EW-1:0];
        if (cur_low_q < vin_rdata[VW-1:0]) begin
          vin_we    = 1'b1;
          vin_waddr = cur_v_q;
          vin_wdata = {vin_rdata[2*VW-1:VW], cur_low_q};
        end else begin
          cur_low_d = vin_rdata[VW-1:0];
        end
        state_d = ST_LOOP;
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          out_valid_d  = 1'b1;
          out_v_d      = pend_v_q;
          out_root_d   = pend_root_q;
          out_loc_d    = pend_loc_q;
          out_lor_d    = 1'b1;
          out_drop_d   = pend_drop_q;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      vcount_q     <= '0;
      stored_q     <= '0;
      dropped_q    <= 1'b0;
      list_valid_q <= '0;
      visited_q    <= '0;
      on_stack_q   <= '0;
      root_q       <= '0;
      cnt_q        <= '0;
      ctop_q       <= '0;
      call_top_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      vcount_q     <= vcount_d;
      stored_q     <= stored_d;
      dropped_q    <= dropped_d;
      list_valid_q <= list_valid_d;
      visited_q    <= visited_d;
      on_stack_q   <= on_stack_d;
      root_q       <= root_d;
      cnt_q        <= cnt_d;
      ctop_q       <= ctop_d;
      call_top_q   <= call_top_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    dst_q       <= dst_d;
    vw_q        <= vw_d;
    cur_v_q     <= cur_v_d;
    cur_null_q  <= cur_null_d;
    cur_c_q     <= cur_c_d;
    cur_last_q  <= cur_last_d;
    cur_idx_q   <= cur_idx_d;
    cur_low_q   <= cur_low_d;
    pend_v_q    <= pend_v_d;
    pend_root_q <= pend_root_d;
    pend_loc_q  <= pend_loc_d;
    pend_drop_q <= pend_drop_d;
    out_v_q     <= out_v_d;
    out_root_q  <= out_root_d;
    out_loc_q   <= out_loc_d;
    out_lor_q   <= out_lor_d;
    out_drop_q  <= out_drop_d;
  end

  assign out_valid_o         = out_valid_q;
  assign vertex_o            = scc_pkg::VertexW'(out_v_q);
  assign component_root_o    = scc_pkg::VertexW'(out_root_q);
  assign last_of_component_o = out_loc_q;
  assign last_of_run_o       = out_lor_q;
  assign edges_dropped_o     = out_drop_q;

  // edge targets
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_tgt_ram (
    .clk_i, .we_i(tgt_we), .waddr_i(tgt_waddr), .wdata_i(tgt_wdata),
    .re_i(tgt_re), .raddr_i(tgt_raddr), .rdata_o(tgt_rdata)
  );

  // edge links
  scc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_lnk_ram (
    .clk_i, .we_i(lnk_we), .waddr_i(lnk_waddr), .wdata_i(lnk_wdata),
    .re_i(lnk_re), .raddr_i(lnk_raddr), .rdata_o(lnk_rdata)
  );

  // list head and tail per vertex
  scc_ram #(.WIDTH(2*EW), .DEPTH(MAX_VERTICES)) u_lst_ram (
    .clk_i, .we_i(lst_we), .waddr_i(lst_waddr), .wdata_i(lst_wdata),
    .re_i(lst_re), .raddr_i(lst_raddr), .rdata_o(lst_rdata)
  );

  // visit index and low link per vertex
  scc_ram #(.WIDTH(2*VW), .DEPTH(MAX_VERTICES)) u_vin_ram (
    .clk_i, .we_i(vin_we), .waddr_i(vin_waddr), .wdata_i(vin_wdata),
    .re_i(vin_re), .raddr_i(vin_raddr), .rdata_o(vin_rdata)
  );

  // component stack
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_cst_ram (
    .clk_i, .we_i(cst_we), .waddr_i(cst_waddr), .wdata_i(cst_wdata),
    .re_i(cst_re), .raddr_i(cst_raddr), .rdata_o(cst_rdata)
  );

  // call stack: vertex, end-of-list flag and edge cursor per frame
  scc_ram #(.WIDTH(CALW), .DEPTH(MAX_VERTICES)) u_cal_ram (
    .clk_i, .we_i(cal_we), .waddr_i(cal_waddr), .wdata_i(cal_wdata),
    .re_i(cal_re), .raddr_i(cal_raddr), .rdata_o(cal_rdata)
  );

  // every frame's vertex still sits on the component stack
  a_stack_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    call_top_q <= ctop_q)
    else $error("call stack deeper than component stack");

  // idle means no open frame and no held-back result
  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (call_top_q == '0) && !pend_valid_q)
    else $error("idle with search state left over");

  // a run with a held-back result ends with that final result marked
  a_run_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) && pend_valid_q && slot_free |=>
      out_valid_q && out_lor_q && (state_q == ST_IDLE))
    else $error("final result not marked");

endmodule

### tb/sv/tb_strongly_connected_components.sv
// ----------------------------------------------------------------------------
// tb_strongly_connected_components
// Self-checking bench for the component search block. Requests (add edge,
// clear, run, no-op) are driven with random gaps; a scoreboard class keeps
// its own edge lists and runs its own Tarjan search on every accepted run
// request, then checks each reported vertex against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_strongly_connected_components;

  localparam int unsigned NumVert  = scc_pkg::DefMaxVertices;
  localparam int unsigned NumEdge  = scc_pkg::DefMaxEdges;
  localparam int unsigned NoEdge   = NumEdge;
  localparam int unsigned Unseen   = 255;
  localparam int unsigned StallCap = 20000;

  typedef struct packed {
    logic [scc_pkg::VertexW-1:0] vertex;
    logic [scc_pkg::VertexW-1:0] root;
    logic                        last_comp;
    logic                        last_run;
    logic                        dropped;
  } scc_result_t;

  // Scoreboard: mirrors the edge store and works out what each run reports.
  class scc_scoreboard;
    int unsigned tgt[NumEdge];
    int unsigned link[NumEdge];
    int unsigned first[NumVert];
    int unsigned last[NumVert];
    int unsigned stored;
    bit          dropped;
    int unsigned vcount;
    scc_result_t pending[$];
    int unsigned errors;

    function void clear_lists();
      for (int v = 0; v < NumVert; v++) begin
        first[v] = NoEdge;
        last[v]  = 0;
      end
      stored  = 0;
      dropped = 0;
    endfunction

    function new();
      clear_lists();
      vcount = 0;
      errors = 0;
    endfunction

    function int unsigned active_count();
      return (vcount > NumVert) ? NumVert : vcount;
    endfunction

    // Tarjan search with an explicit call stack, filling pending in pop order.
    function void search();
      int unsigned n, vidx[NumVert], low[NumVert], stk[NumVert], cv[NumVert];
      int unsigned cc[NumVert], ctop, stop, cnt, f, v, c, w, p, made;
      bit          onstk[NumVert];
      scc_result_t r;
      n = active_count();
      for (int i = 0; i < NumVert; i++) begin
        vidx[i] = Unseen;
        onstk[i] = 0;
      end
      ctop = 0; stop = 0; cnt = 0; made = 0;
      for (int unsigned rt = 0; rt < n; rt++) begin
        if (vidx[rt] != Unseen) continue;
        vidx[rt] = cnt; low[rt] = cnt; cnt++;
        stk[stop] = rt; stop++; onstk[rt] = 1;
        cv[ctop] = rt; cc[ctop] = first[rt]; ctop++;
        while (ctop > 0) begin
          f = ctop - 1;
          v = cv[f];
          c = cc[f];
          if (c >= NoEdge) begin
            ctop--;
            if (low[v] == vidx[v]) begin
              do begin
                stop--;
                w = stk[stop];
                onstk[w] = 0;
                r.vertex = w; r.root = v; r.last_comp = (w == v);
                r.last_run = 0; r.dropped = dropped;
                pending.push_back(r);
                made++;
              end while (w != v && stop > 0);
            end
            if (ctop > 0) begin
              p = cv[ctop-1];
              if (low[v] < low[p]) low[p] = low[v];
            end
            continue;
          end
          w = tgt[c];
          cc[f] = (c == last[v]) ? NoEdge : link[c];
          if (w >= n) continue;
          if (vidx[w] == Unseen) begin
            vidx[w] = cnt; low[w] = cnt; cnt++;
            stk[stop] = w; stop++; onstk[w] = 1;
            cv[ctop] = w; cc[ctop] = first[w]; ctop++;
          end else if (onstk[w] && vidx[w] < low[v]) begin
            low[v] = vidx[w];
          end
        end
      end
      if (made > 0) begin
        r = pending.pop_back();
        r.last_run = 1;
        pending.push_back(r);
      end
    endfunction

    // Note an accepted request.
    function void note_request(logic [scc_pkg::ActionW-1:0] act, int unsigned s,
                               int unsigned d);
      int unsigned n;
      n = active_count();
      case (act)
        scc_pkg::ActAddEdge: begin
          if (s >= n || d >= n || stored >= NumEdge) begin
            dropped = 1;
          end else begin
            tgt[stored] = d;
            link[stored] = 0;
            if (first[s] >= NoEdge) first[s] = stored;
            else link[last[s]] = stored;
            last[s] = stored;
            stored++;
          end
        end
        scc_pkg::ActClear: clear_lists();
        scc_pkg::ActRun:   search();
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Check one accepted result against the oldest prediction.
    task check_result(scc_result_t got);
      scc_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result, vertex %0d", got.vertex));
        return;
      end
      want = pending.pop_front();
      if (got.vertex != want.vertex)
        report($sformatf("vertex got %0d want %0d", got.vertex, want.vertex));
      if (got.root != want.root)
        report($sformatf("component_root got %0d want %0d", got.root, want.root));
      if (got.last_comp != want.last_comp)
        report($sformatf("last_of_component got %0d want %0d", got.last_comp,
                         want.last_comp));
      if (got.last_run != want.last_run)
        report($sformatf("last_of_run got %0d want %0d", got.last_run, want.last_run));
      if (got.dropped != want.dropped)
        report($sformatf("edges_dropped got %0d want %0d", got.dropped, want.dropped));
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [scc_pkg::VertCountW-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [scc_pkg::ActionW-1:0]    action_i = scc_pkg::ActNop;
  logic [scc_pkg::VertexW-1:0]    src_vertex_i = '0;
  logic [scc_pkg::VertexW-1:0]    dst_vertex_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [scc_pkg::VertexW-1:0]    vertex_o;
  logic [scc_pkg::VertexW-1:0]    component_root_o;
  logic                           last_of_component_o;
  logic                           last_of_run_o;
  logic                           edges_dropped_o;

  strongly_connected_components dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .action_i, .src_vertex_i, .dst_vertex_i,
    .out_valid_o, .out_ready_i, .vertex_o, .component_root_o,
    .last_of_component_o, .last_of_run_o, .edges_dropped_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  scc_scoreboard sb = new();
  int unsigned   quiet_cycles = 0;
  int unsigned   hold_req = 0;   // long receiver stalls asked for by stimulus

  // Gap length: mostly short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Check each accepted result at the edge and count quiet cycles.
  always @(posedge clk_i) begin
    scc_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{vertex_o, component_root_o, last_of_component_o, last_of_run_o,
              edges_dropped_o};
      sb.check_result(got);
    end
    if (rst_ni && ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : receiver
    int unsigned g;
    int unsigned hold_done;
    hold_done = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Offer one request and hold it until accepted; valid stays up afterwards
  // so that a following request can go out with no gap.
  task automatic send(logic [scc_pkg::ActionW-1:0] act, int unsigned s, int unsigned d);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    src_vertex_i <= s[scc_pkg::VertexW-1:0];
    dst_vertex_i <= d[scc_pkg::VertexW-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(act, s & 32'd63, d & 32'd63);
  endtask

  // Drain predictions, let the block settle, then write vertex_count.
  task automatic set_vertex_count(int unsigned val);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val[scc_pkg::VertCountW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.vcount = val;
  endtask

  // Clear, random edges among n vertices (some may drop), then a run.
  task automatic random_graph(int unsigned n, int unsigned edges);
    int unsigned s, d;
    send(scc_pkg::ActClear, $urandom, $urandom);
    for (int i = 0; i < edges; i++) begin
      s = $urandom_range(0, n - 1);
      d = ($urandom_range(0, 3) == 0) ? (s + 1) % n : $urandom_range(0, n - 1);
      if ($urandom_range(0, 19) == 0) s = $urandom_range(0, 63);  // odd drop
      send(scc_pkg::ActAddEdge, s, d);
    end
    if ($urandom_range(0, 7) == 0) send(scc_pkg::ActNop, $urandom, $urandom);
    send(scc_pkg::ActRun, $urandom, $urandom);
  endtask

  initial begin : stimulus
    int unsigned n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty graph, drops at the count boundary, cycle, stale edges.
    send(scc_pkg::ActRun, 0, 0);
    send(scc_pkg::ActAddEdge, 0, 0);
    set_vertex_count(64);
    send(scc_pkg::ActAddEdge, 63, 0);
    send(scc_pkg::ActAddEdge, 0, 63);
    send(scc_pkg::ActAddEdge, 63, 63);
    send(scc_pkg::ActRun, 0, 0);
    send(scc_pkg::ActClear, 63, 63);
    set_vertex_count(3);
    send(scc_pkg::ActAddEdge, 0, 1);
    send(scc_pkg::ActAddEdge, 1, 2);
    send(scc_pkg::ActAddEdge, 2, 0);
    send(scc_pkg::ActAddEdge, 2, 3);
    send(scc_pkg::ActNop, 42, 21);
    send(scc_pkg::ActRun, 0, 0);
    set_vertex_count(2);
    send(scc_pkg::ActRun, 0, 0);     // edges to vertex 2 now stale
    set_vertex_count(127);           // above the vertex limit, clipped
    send(scc_pkg::ActRun, 0, 0);
    set_vertex_count(1);
    send(scc_pkg::ActClear, 0, 0);
    send(scc_pkg::ActAddEdge, 0, 0);
    send(scc_pkg::ActRun, 0, 0);

    // Dense graph on all vertices, with a long receiver stall over its run
    // while a second run waits at the input.
    set_vertex_count(64);
    send(scc_pkg::ActClear, 0, 0);
    for (int i = 0; i < 100; i++)
      send(scc_pkg::ActAddEdge, $urandom_range(0, 63), $urandom_range(0, 63));
    hold_req++;
    send(scc_pkg::ActRun, 0, 0);
    send(scc_pkg::ActRun, 0, 0);

    // Random: mostly well-formed graphs on small counts, a few on 64.
    for (int k = 0; k < 24; k++) begin
      n = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 12);
      if (k == 23) n = 0;
      set_vertex_count(n);
      if (n == 0) send(scc_pkg::ActRun, 0, 0);
      else random_graph(n, $urandom_range(0, (n > 12) ? 24 : 2 * n));
    end

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0)
      $display("strongly_connected_components regression: pass");
    else
      $display("strongly_connected_components regression: fail");
    $finish;
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (quiet_cycles >= StallCap) begin
      $display("strongly_connected_components regression: fail");
      $finish;
    end
  end

endmodule
